FILE: rtl/core/bps_pkg.sv
`default_nettype none

package bps_pkg;

   // Command codes carried in the cmd field.
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_START  = 3'd1;
   localparam logic [2:0] CMD_STOP   = 3'd2;
   localparam logic [2:0] CMD_STEADY = 3'd3;
   localparam logic [2:0] CMD_LOAD   = 3'd4;

   // Pattern kinds selected by a start command.
   localparam logic [2:0] KIND_CUSTOM     = 3'd0;
   localparam logic [2:0] KIND_BEEP       = 3'd1;
   localparam logic [2:0] KIND_SHORT      = 3'd2;
   localparam logic [2:0] KIND_LONG       = 3'd3;
   localparam logic [2:0] KIND_DOUBLE     = 3'd4;
   localparam logic [2:0] KIND_TRIPLE     = 3'd5;
   localparam logic [2:0] KIND_LONG_SHORT = 3'd6;
   localparam logic [2:0] KIND_CONTINUOUS = 3'd7;

   // Gap sources for custom tables.
   localparam logic [1:0] OFF_INTERVAL  = 2'd0;
   localparam logic [1:0] OFF_SHARED    = 2'd1;
   localparam logic [1:0] OFF_PER_ENTRY = 2'd2;
   localparam logic [1:0] OFF_INVALID   = 2'd3;

   // Start status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_ZERO_ON     = 2'd1;
   localparam logic [1:0] ST_ZERO_REPEAT = 2'd2;
   localparam logic [1:0] ST_BAD_ARG     = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SHORT    = 2'd0;
   localparam logic [1:0] CSR_LONG     = 2'd1;
   localparam logic [1:0] CSR_INTERVAL = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [15:0] SHORT_MS_RESET    = 16'd100;
   localparam logic [15:0] LONG_MS_RESET     = 16'd500;
   localparam logic [15:0] INTERVAL_MS_RESET = 16'd100;

   // Sequencer phase.
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_OFF  = 2'd2,
      PH_CONT = 2'd3
   } phase_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [2:0]  pattern_kind;
      logic [3:0]  seg_index;
      logic [15:0] seg_on_ms;
      logic [15:0] seg_off_ms;
      logic [4:0]  seg_count;
      logic [1:0]  off_mode;
      logic [15:0] repeat_count;
   } req_item_type;

   typedef struct packed {
      logic       pin_level;
      logic       busy_res;
      logic       finished;
      logic [1:0] status;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: rtl/core/bps_seg_table.sv
`default_nettype none

module bps_seg_table #(
   parameter int DEPTH     = 16,
   parameter int IDX_W     = 4,
   parameter int TIME_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [IDX_W-1:0]     wr_idx,
   input  wire logic [TIME_BITS-1:0] wr_on,
   input  wire logic [TIME_BITS-1:0] wr_off,
   input  wire logic                 wr_zero_on,
   input  wire logic [IDX_W-1:0]     on_idx,
   input  wire logic [IDX_W-1:0]     off_idx,
   output logic [TIME_BITS-1:0]      on_data,
   output logic [TIME_BITS-1:0]      off_data,
   output logic [DEPTH-1:0]          zero_mask
);

   logic [TIME_BITS-1:0] on_ff  [DEPTH];
   logic [TIME_BITS-1:0] off_ff [DEPTH];
   logic [DEPTH-1:0]     zero_mask_ff;

   // Segment times; contents are meaningful only once loaded.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         on_ff[wr_idx]  <= wr_on;
         off_ff[wr_idx] <= wr_off;
      end
   end

   // An entry counts as zero on time until it is loaded with a nonzero one.
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_mask_ff <= '1;
      end else if (wr_en) begin
         zero_mask_ff[wr_idx] <= wr_zero_on;
      end
   end

   assign on_data   = on_ff[on_idx];
   assign off_data  = off_ff[off_idx];
   assign zero_mask = zero_mask_ff;

endmodule

`default_nettype wire

FILE: rtl/core/beep_pattern_sequencer_core.sv
// Beep pattern sequencer for an active-low buzzer pin.
//
// Items arrive on the req_ channel: millisecond ticks, start, stop, steady on
// and segment loads. Every accepted item produces exactly one result on the
// rsp_ channel carrying the pin level, busy flag, finished flag and a start
// status. A transfer happens on a rising edge with valid high and stall low.
//
// An item is captured in an input register, evaluated against the sequencer
// state and written to the result register, from which the result can
// transfer. One item per cycle is sustained while rsp_stall stays low; the
// loop through the countdown state sets that rate.
//
// When rsp_stall holds the result register, the input register still takes
// one more item and then req_stall rises until the result is taken.
// The csr_ port writes short_ms, long_ms and interval_ms; it is always ready
// and should be written only while no items are in flight.
// Synchronous reset returns the sequencer to idle, restores the register
// defaults and marks every table entry as unloaded.

`default_nettype none

module beep_pattern_sequencer_core #(
   parameter int MAX_SEGMENTS = 16,
   parameter int TIME_BITS    = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire bps_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output bps_pkg::rsp_item_type      rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_data
);

   import bps_pkg::*;

   // Only sixteen entries can ever be loaded through a 4-bit index.
   localparam int SEG_DEPTH = (MAX_SEGMENTS < 16) ? MAX_SEGMENTS : 16;
   localparam int TBL_IDX_W = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
   localparam int SEQ_IDX_W = (TBL_IDX_W < 2) ? 2 : TBL_IDX_W;
   localparam logic [31:0] TIME_MAX32 = 32'((64'd1 << TIME_BITS) - 64'd1);
   localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

   function automatic logic [TIME_BITS-1:0] sat_time(input logic [15:0] v);
      logic [31:0] v32;
      v32 = {16'd0, v};
      return (v32 > TIME_MAX32) ? TIME_MAX32[TIME_BITS-1:0] : v32[TIME_BITS-1:0];
   endfunction

   // Handshake and pipeline registers.
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_data_ff;
   logic         advance;
   logic         req_take;

   // Configuration registers.
   logic [15:0] short_ff, long_ff, interval_ff;

   // Sequencer state and its next values.
   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] remaining_ff, remaining_in;
   logic [SEQ_IDX_W-1:0] seg_idx_ff, seg_idx_in;
   logic [15:0]          repeats_ff, repeats_in;
   logic [2:0]           kind_ff, kind_in;
   logic [4:0]           count_ff, count_in;
   logic [1:0]           off_mode_ff, off_mode_in;
   logic [TIME_BITS-1:0] beep_ff, beep_in;
   logic                 finished_c;
   logic [1:0]           status_c;
   rsp_item_type         rsp_in;

   // Evaluation helpers.
   logic                 is_start;
   logic [4:0]           seg_inc;
   logic                 has_more;
   logic [SEQ_IDX_W-1:0] nxt_idx;
   logic [2:0]           eff_kind;
   logic [SEQ_IDX_W-1:0] eff_idx;
   logic [TIME_BITS-1:0] eff_beep;
   logic [TIME_BITS-1:0] on_val;
   logic [TIME_BITS-1:0] off_val;
   logic                 has_next;
   logic                 mask_hit;
   logic [1:0]           start_status;

   // Table interface.
   logic                 tbl_wr_en;
   logic [TBL_IDX_W-1:0] tbl_on_idx, tbl_off_idx;
   logic [TIME_BITS-1:0] tbl_on, tbl_off;
   logic [SEG_DEPTH-1:0] tbl_zero_mask;

   // Pipeline moves when the result register is free or being drained.
   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // Configuration writes; a zero beep length is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff    <= SHORT_MS_RESET;
         long_ff     <= LONG_MS_RESET;
         interval_ff <= INTERVAL_MS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SHORT: begin
               if (csr_data != 16'd0) short_ff <= csr_data;
            end
            CSR_LONG: begin
               if (csr_data != 16'd0) long_ff <= csr_data;
            end
            CSR_INTERVAL: begin
               interval_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Segment table.
   assign tbl_wr_en = advance && (in_item_ff.cmd == CMD_LOAD) &&
                      (32'(in_item_ff.seg_index) < SEG_DEPTH);

   bps_seg_table #(
      .DEPTH     (SEG_DEPTH),
      .IDX_W     (TBL_IDX_W),
      .TIME_BITS (TIME_BITS)
   ) u_seg_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (tbl_wr_en),
      .wr_idx     (in_item_ff.seg_index[TBL_IDX_W-1:0]),
      .wr_on      (sat_time(in_item_ff.seg_on_ms)),
      .wr_off     (sat_time(in_item_ff.seg_off_ms)),
      .wr_zero_on (in_item_ff.seg_on_ms == 16'd0),
      .on_idx     (tbl_on_idx),
      .off_idx    (tbl_off_idx),
      .on_data    (tbl_on),
      .off_data   (tbl_off),
      .zero_mask  (tbl_zero_mask)
   );

   // Segment position, and the on and off times of the next step.
   always_comb begin
      is_start = (in_item_ff.cmd == CMD_START);
      seg_inc  = 5'(seg_idx_ff) + 5'd1;
      has_more = (seg_inc < count_ff);
      nxt_idx  = has_more ? seg_inc[SEQ_IDX_W-1:0] : '0;
      has_next = has_more || (repeats_ff > 16'd1);

      eff_kind = is_start ? in_item_ff.pattern_kind : kind_ff;
      eff_idx  = is_start ? '0 : nxt_idx;
      eff_beep = is_start ? sat_time(in_item_ff.seg_on_ms) : beep_ff;

      tbl_on_idx  = eff_idx[TBL_IDX_W-1:0];
      tbl_off_idx = (off_mode_ff == OFF_SHARED) ? '0 : seg_idx_ff[TBL_IDX_W-1:0];

      unique case (eff_kind)
         KIND_CUSTOM:     on_val = tbl_on;
         KIND_BEEP:       on_val = eff_beep;
         KIND_LONG:       on_val = sat_time(long_ff);
         KIND_LONG_SHORT: on_val = (eff_idx == '0) ? sat_time(long_ff) : sat_time(short_ff);
         default:         on_val = sat_time(short_ff);
      endcase

      priority if (kind_ff == KIND_BEEP) begin
         off_val = '0;
      end else if (kind_ff == KIND_CUSTOM && (off_mode_ff == OFF_SHARED ||
                                              off_mode_ff == OFF_PER_ENTRY)) begin
         off_val = tbl_off;
      end else begin
         off_val = sat_time(interval_ff);
      end
   end

   // Start checks, in order of precedence.
   always_comb begin
      mask_hit = (32'(in_item_ff.seg_count) > SEG_DEPTH);
      for (int i = 0; i < SEG_DEPTH; i++) begin
         if (32'(in_item_ff.seg_count) > i && tbl_zero_mask[i]) mask_hit = 1'b1;
      end

      start_status = ST_OK;
      unique case (in_item_ff.pattern_kind)
         KIND_CUSTOM: begin
            priority if (in_item_ff.seg_count == 5'd0 ||
                         32'(in_item_ff.seg_count) > MAX_SEGMENTS) begin
               start_status = ST_BAD_ARG;
            end else if (in_item_ff.repeat_count == 16'd0) begin
               start_status = ST_ZERO_REPEAT;
            end else if (mask_hit) begin
               start_status = ST_ZERO_ON;
            end else if (in_item_ff.off_mode == OFF_INVALID) begin
               start_status = ST_BAD_ARG;
            end else begin
               start_status = ST_OK;
            end
         end
         KIND_BEEP: begin
            if (in_item_ff.seg_on_ms == 16'd0) start_status = ST_ZERO_ON;
         end
         KIND_SHORT, KIND_LONG: begin
            if (in_item_ff.repeat_count == 16'd0) start_status = ST_ZERO_REPEAT;
         end
         default: begin
         end
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      seg_idx_in   = seg_idx_ff;
      repeats_in   = repeats_ff;
      kind_in      = kind_ff;
      count_in     = count_ff;
      off_mode_in  = off_mode_ff;
      beep_in      = beep_ff;
      finished_c   = 1'b0;
      status_c     = ST_OK;

      unique case (in_item_ff.cmd)
         CMD_TICK: begin
            unique case (phase_ff)
               PH_ON: begin
                  if (remaining_ff > TIME_ONE) begin
                     remaining_in = remaining_ff - TIME_ONE;
                  end else if (!has_next) begin
                     phase_in     = PH_IDLE;
                     remaining_in = '0;
                     finished_c   = 1'b1;
                  end else if (off_val != '0) begin
                     phase_in     = PH_OFF;
                     remaining_in = off_val;
                  end else begin
                     seg_idx_in   = nxt_idx;
                     phase_in     = PH_ON;
                     remaining_in = on_val;
                     if (!has_more && repeats_ff != 16'd0) repeats_in = repeats_ff - 16'd1;
                  end
               end
               PH_OFF: begin
                  if (remaining_ff > TIME_ONE) begin
                     remaining_in = remaining_ff - TIME_ONE;
                  end else begin
                     seg_idx_in   = nxt_idx;
                     phase_in     = PH_ON;
                     remaining_in = on_val;
                     if (!has_more && repeats_ff != 16'd0) repeats_in = repeats_ff - 16'd1;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_START: begin
            status_c = start_status;
            if (start_status == ST_OK) begin
               kind_in     = in_item_ff.pattern_kind;
               off_mode_in = (in_item_ff.pattern_kind == KIND_CUSTOM) ?
                             in_item_ff.off_mode : OFF_INTERVAL;
               seg_idx_in  = '0;
               unique case (in_item_ff.pattern_kind)
                  KIND_CUSTOM: begin
                     count_in   = in_item_ff.seg_count;
                     repeats_in = in_item_ff.repeat_count;
                  end
                  KIND_SHORT, KIND_LONG: begin
                     count_in   = 5'd1;
                     repeats_in = in_item_ff.repeat_count;
                  end
                  KIND_DOUBLE, KIND_LONG_SHORT: begin
                     count_in   = 5'd2;
                     repeats_in = 16'd1;
                  end
                  KIND_TRIPLE: begin
                     count_in   = 5'd3;
                     repeats_in = 16'd1;
                  end
                  default: begin
                     count_in   = 5'd1;
                     repeats_in = 16'd1;
                  end
               endcase
               if (in_item_ff.pattern_kind == KIND_BEEP) beep_in = eff_beep;
               if (in_item_ff.pattern_kind == KIND_CONTINUOUS) begin
                  phase_in     = PH_CONT;
                  remaining_in = '0;
               end else begin
                  phase_in     = PH_ON;
                  remaining_in = on_val;
               end
            end
         end
         CMD_STOP: begin
            phase_in     = PH_IDLE;
            remaining_in = '0;
         end
         CMD_STEADY: begin
            phase_in     = PH_CONT;
            remaining_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Result fields follow the state after this item.
   always_comb begin
      rsp_in.pin_level = !(phase_in == PH_ON || phase_in == PH_CONT);
      rsp_in.busy_res  = (phase_in != PH_IDLE);
      rsp_in.finished  = finished_c;
      rsp_in.status    = status_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         remaining_ff <= '0;
         seg_idx_ff   <= '0;
         repeats_ff   <= '0;
         kind_ff      <= KIND_CUSTOM;
         count_ff     <= '0;
         off_mode_ff  <= OFF_INTERVAL;
         beep_ff      <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         seg_idx_ff   <= seg_idx_in;
         repeats_ff   <= repeats_in;
         kind_ff      <= kind_in;
         count_ff     <= count_in;
         off_mode_ff  <= off_mode_in;
         beep_ff      <= beep_in;
      end
   end

   // A gap is only entered with time left, and it ends before reaching zero.
   a_off_has_time: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_OFF |-> remaining_ff != '0)
      else $error("gap phase with zero remaining time");

   // Input side stalls only while a stalled result is held and the input register is full.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall && in_valid_ff)
      else $error("input stalled without a held result");

   // A finished pattern leaves the pin silent and the block idle.
   a_finished_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.finished |->
         !rsp_data_ff.busy_res && rsp_data_ff.pin_level)
      else $error("finished flag with sequencer still running");

   // A result is produced exactly when the evaluated item leaves the input register.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("evaluated item produced no result");

endmodule

`default_nettype wire

FILE: tb/sv/bps_checker.sv
module bps_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire bps_pkg::req_item_type req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire bps_pkg::rsp_item_type rsp_data,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_data,
   output int                         error_count,
   output int                         pending_count,
   output int                         checked_count,
   output int                         completed_count
);
   import bps_pkg::*;

   localparam int TABLE_DEPTH = 16;

   // Shadow copy of the timing registers.
   logic [15:0] short_ms_reg;
   logic [15:0] long_ms_reg;
   logic [15:0] interval_ms_reg;

   // Shadow copy of the custom table and the sequencer state.
   logic [15:0]            on_tab [TABLE_DEPTH];
   logic [15:0]            off_tab [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] zero_on;
   phase_type              phase_q;
   logic [15:0]            time_left;
   logic [3:0]             seg_pos;
   logic [15:0]            passes_left;
   logic [2:0]             run_kind;
   logic [4:0]             run_count;
   logic [1:0]             run_gap_mode;
   logic [15:0]            beep_len;

   // Pin outcomes still owed by the block, oldest first.
   rsp_item_type pending_outcomes[$];

   // On time of segment i of the running pattern.
   function automatic logic [15:0] on_time(int i);
      case (run_kind)
         KIND_CUSTOM:     return on_tab[i];
         KIND_BEEP:       return beep_len;
         KIND_LONG:       return long_ms_reg;
         KIND_LONG_SHORT: return (i == 0) ? long_ms_reg : short_ms_reg;
         default:         return short_ms_reg;
      endcase
   endfunction

   // Gap that follows segment i of the running pattern.
   function automatic logic [15:0] gap_time(int i);
      if (run_kind == KIND_BEEP) return 16'd0;
      if (run_kind == KIND_CUSTOM) begin
         if (run_gap_mode == OFF_SHARED) return off_tab[0];
         if (run_gap_mode == OFF_PER_ENTRY) return off_tab[i];
      end
      return interval_ms_reg;
   endfunction

   // Step to the next segment, wrapping into the next repeat.
   function automatic void advance_segment();
      if (int'(seg_pos) + 1 < int'(run_count)) begin
         seg_pos++;
      end else begin
         seg_pos = '0;
         if (passes_left > 0) passes_left--;
      end
      phase_q = PH_ON;
      time_left = on_time(int'(seg_pos));
   endfunction

   // An on segment ran out. Returns 1 when the whole pattern is over.
   function automatic bit end_of_on();
      bit          more;
      logic [15:0] gap;
      more = (int'(seg_pos) + 1 < int'(run_count)) || (passes_left > 1);
      if (!more) begin
         phase_q = PH_IDLE;
         time_left = '0;
         return 1'b1;
      end
      gap = gap_time(int'(seg_pos));
      if (gap > 0) begin
         phase_q = PH_OFF;
         time_left = gap;
      end else begin
         advance_segment();
      end
      return 1'b0;
   endfunction

   // Status of a start command, checked in the order the block applies.
   function automatic logic [1:0] start_status(req_item_type it);
      int i;
      if (it.pattern_kind == KIND_CUSTOM) begin
         if (it.seg_count == 0 || it.seg_count > TABLE_DEPTH) return ST_BAD_ARG;
         if (it.repeat_count == 0) return ST_ZERO_REPEAT;
         for (i = 0; i < int'(it.seg_count); i++)
            if (zero_on[i]) return ST_ZERO_ON;
         if (it.off_mode == OFF_INVALID) return ST_BAD_ARG;
      end else if (it.pattern_kind == KIND_BEEP) begin
         if (it.seg_on_ms == 0) return ST_ZERO_ON;
      end else if (it.pattern_kind == KIND_SHORT || it.pattern_kind == KIND_LONG) begin
         if (it.repeat_count == 0) return ST_ZERO_REPEAT;
      end
      return ST_OK;
   endfunction

   // Apply one command to the shadow state and return the pin outcome.
   function automatic rsp_item_type sequencer_outcome(req_item_type it);
      rsp_item_type r;
      logic [1:0]   st;
      bit           done;
      st = ST_OK;
      done = 1'b0;
      case (it.cmd)
         CMD_TICK: begin
            if (phase_q == PH_ON) begin
               if (time_left > 1) time_left--;
               else done = end_of_on();
            end else if (phase_q == PH_OFF) begin
               if (time_left > 1) time_left--;
               else advance_segment();
            end
         end
         CMD_START: begin
            st = start_status(it);
            if (st == ST_OK) begin
               run_kind = it.pattern_kind;
               run_gap_mode = (it.pattern_kind == KIND_CUSTOM) ? it.off_mode : OFF_INTERVAL;
               seg_pos = '0;
               case (it.pattern_kind)
                  KIND_CUSTOM: begin
                     run_count = it.seg_count;
                     passes_left = it.repeat_count;
                  end
                  KIND_SHORT, KIND_LONG: begin
                     run_count = 5'd1;
                     passes_left = it.repeat_count;
                  end
                  KIND_DOUBLE, KIND_LONG_SHORT: begin
                     run_count = 5'd2;
                     passes_left = 16'd1;
                  end
                  KIND_TRIPLE: begin
                     run_count = 5'd3;
                     passes_left = 16'd1;
                  end
                  default: begin
                     run_count = 5'd1;
                     passes_left = 16'd1;
                  end
               endcase
               if (it.pattern_kind == KIND_BEEP) beep_len = it.seg_on_ms;
               if (it.pattern_kind == KIND_CONTINUOUS) begin
                  phase_q = PH_CONT;
                  time_left = '0;
               end else begin
                  phase_q = PH_ON;
                  time_left = on_time(0);
               end
            end
         end
         CMD_STOP: begin
            phase_q = PH_IDLE;
            time_left = '0;
         end
         CMD_STEADY: begin
            phase_q = PH_CONT;
            time_left = '0;
         end
         CMD_LOAD: begin
            on_tab[it.seg_index] = it.seg_on_ms;
            off_tab[it.seg_index] = it.seg_off_ms;
            zero_on[it.seg_index] = (it.seg_on_ms == 0);
         end
         default: ;
      endcase
      if (done) completed_count++;
      r.pin_level = (phase_q == PH_ON || phase_q == PH_CONT) ? 1'b0 : 1'b1;
      r.busy_res = (phase_q != PH_IDLE);
      r.finished = done;
      r.status = st;
      return r;
   endfunction

   // Compare results, track register writes and predict each accepted command.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         short_ms_reg = SHORT_MS_RESET;
         long_ms_reg = LONG_MS_RESET;
         interval_ms_reg = INTERVAL_MS_RESET;
         zero_on = '1;
         phase_q = PH_IDLE;
         time_left = '0;
         seg_pos = '0;
         passes_left = '0;
         run_kind = KIND_CUSTOM;
         run_count = '0;
         run_gap_mode = OFF_INTERVAL;
         beep_len = '0;
         pending_outcomes.delete();
         error_count = 0;
         pending_count = 0;
         checked_count = 0;
         completed_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: result transfer with nothing outstanding: pin=%b busy=%b fin=%b st=%0d",
                           $realtime, rsp_data.pin_level, rsp_data.busy_res,
                           rsp_data.finished, rsp_data.status);
               error_count++;
            end else begin
               want = pending_outcomes.pop_front();
               checked_count++;
               if (want.pin_level !== rsp_data.pin_level || want.busy_res !== rsp_data.busy_res ||
                   want.finished !== rsp_data.finished || want.status !== rsp_data.status) begin
                  if (error_count < 10)
                     $display("%0t: mismatch: expected pin=%b busy=%b fin=%b st=%0d, got pin=%b busy=%b fin=%b st=%0d",
                              $realtime, want.pin_level, want.busy_res, want.finished,
                              want.status, rsp_data.pin_level, rsp_data.busy_res,
                              rsp_data.finished, rsp_data.status);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SHORT:    if (csr_data != 0) short_ms_reg = csr_data;
               CSR_LONG:     if (csr_data != 0) long_ms_reg = csr_data;
               CSR_INTERVAL: interval_ms_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pending_outcomes.push_back(sequencer_outcome(req_data));
         pending_count = pending_outcomes.size();
      end
   end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
   import bps_pkg::*;

   // A command code the block does not decode.
   localparam logic [2:0] CMD_SPARE = 3'd5;
   localparam int NUM_SETTINGS = 7;
   localparam int ITEMS_PER_SETTING = 155;
   localparam int STALL_LIMIT = 2000;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CSR_SHORT;
   logic [15:0]  csr_data = '0;

   int error_count;
   int pending_count;
   int checked_count;
   int completed_count;
   int commands_sent;
   int burst_left;
   int idle_cycles;
   int stall_span;
   int stall_tick;
   stall_style_type stall_style = STALL_NONE;
   bit [15:0] entry_ready;

   // Register settings walked through in the random part, extremes included.
   logic [15:0] set_short [NUM_SETTINGS] =
      '{16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd0, 16'd4, 16'd1};
   logic [15:0] set_long [NUM_SETTINGS] =
      '{16'd1, 16'd3, 16'd6, 16'hFFFF, 16'd0, 16'd2, 16'd2};
   logic [15:0] set_interval [NUM_SETTINGS] =
      '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd0, 16'd3, 16'd1};

   always #6 clock = ~clock;

   beep_pattern_sequencer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   bps_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .completed_count (completed_count)
   );

   // Result side stalls in randomly chosen styles, each kept for a random span.
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_span = $urandom_range(16, 96);
      end else begin
         stall_span = stall_span - 1;
      end
      stall_tick = stall_tick + 1;
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 2) != 0);
         default:     rsp_stall <= (stall_tick % 5 < 2);
      endcase
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_item_type random_fields();
      req_item_type it;
      it.cmd = 3'($urandom_range(0, 7));
      it.pattern_kind = 3'($urandom_range(0, 7));
      it.seg_index = 4'($urandom_range(0, 15));
      it.seg_on_ms = 16'($urandom_range(0, 65535));
      it.seg_off_ms = 16'($urandom_range(0, 65535));
      it.seg_count = 5'($urandom_range(0, 31));
      it.off_mode = 2'($urandom_range(0, 3));
      it.repeat_count = 16'($urandom_range(0, 65535));
      return it;
   endfunction

   function automatic req_item_type make_item(logic [2:0] cmd, logic [2:0] kind,
                                              logic [3:0] idx, logic [15:0] on_ms,
                                              logic [15:0] off_ms, logic [4:0] cnt,
                                              logic [1:0] mode, logic [15:0] rep);
      req_item_type it;
      it.cmd = cmd;
      it.pattern_kind = kind;
      it.seg_index = idx;
      it.seg_on_ms = on_ms;
      it.seg_off_ms = off_ms;
      it.seg_count = cnt;
      it.off_mode = mode;
      it.repeat_count = rep;
      return it;
   endfunction

   // Send one command; the sender runs in bursts separated by short gaps.
   task automatic send_item(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= it;
      do begin
         @(posedge clock);
      end while (req_stall);
      burst_left--;
      if (it.cmd <= CMD_LOAD) commands_sent++;
      if (it.cmd == CMD_LOAD) entry_ready[it.seg_index] = (it.seg_on_ms != 0);
   endtask

   // Hold the sender until every outstanding result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
   endtask

   task automatic write_setting(input int s);
      write_reg(CSR_SHORT, set_short[s]);
      write_reg(CSR_LONG, set_long[s]);
      write_reg(CSR_INTERVAL, set_interval[s]);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A well-formed run: load the table if needed, start, then mostly ticks.
   task automatic run_pattern();
      req_item_type it;
      int         n;
      int         i;
      int         ticks;
      logic [2:0] kind;
      kind = 3'($urandom_range(0, 7));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
      if (kind == KIND_CUSTOM) begin
         for (i = 0; i < n; i++) begin
            if (!entry_ready[i] || $urandom_range(0, 1) == 1) begin
               it = random_fields();
               it.cmd = CMD_LOAD;
               it.seg_index = 4'(i);
               it.seg_on_ms = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535))
                                                            : 16'($urandom_range(1, 4));
               it.seg_off_ms = 16'($urandom_range(0, 3));
               send_item(it);
            end
         end
      end
      it = random_fields();
      it.cmd = CMD_START;
      it.pattern_kind = kind;
      it.seg_count = 5'(n);
      it.off_mode = 2'($urandom_range(0, 2));
      it.repeat_count = 16'($urandom_range(1, 3));
      it.seg_on_ms = 16'($urandom_range(1, 6));
      send_item(it);
      ticks = $urandom_range(0, 40);
      repeat (ticks) begin
         it = random_fields();
         if ($urandom_range(0, 29) != 0) it.cmd = CMD_TICK;
         send_item(it);
      end
   endtask

   // Random traffic under one register setting.
   task automatic run_setting(input int quota);
      int first;
      int pick;
      first = commands_sent;
      while (commands_sent - first < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) run_pattern();
         else if (pick < 73) drain();
         else send_item(random_fields());
      end
   endtask

   initial begin
      int s;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Rejected custom starts: unloaded entry, count zero, count too large, zero repeat.
      send_item(make_item(CMD_START, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd1, OFF_INTERVAL, 16'd1));
      send_item(make_item(CMD_START, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'd1));
      send_item(make_item(CMD_START, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd31, OFF_INTERVAL, 16'd1));
      send_item(make_item(CMD_START, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd16, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_SPARE, KIND_CONTINUOUS, 4'd15, 16'hFFFF, 16'hFFFF, 5'd31,
                          OFF_INVALID, 16'hFFFF));
      // A zero on time in entry zero keeps a custom start rejected.
      send_item(make_item(CMD_LOAD, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_LOAD, KIND_CUSTOM, 4'd15, 16'hFFFF, 16'hFFFF, 5'd0,
                          OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_START, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd1, OFF_INTERVAL, 16'd1));
      // Two short entries, the first with a zero gap, then a bad gap mode.
      send_item(make_item(CMD_LOAD, KIND_CUSTOM, 4'd0, 16'd2, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_LOAD, KIND_CUSTOM, 4'd1, 16'd1, 16'd3, 5'd0, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_START, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd2, OFF_INVALID, 16'd1));
      // Run the pair once: the zero gap skips ahead and no gap follows the last segment.
      send_item(make_item(CMD_START, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd2, OFF_PER_ENTRY, 16'd1));
      repeat (3)
         send_item(make_item(CMD_TICK, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      // Rejected presets.
      send_item(make_item(CMD_START, KIND_BEEP, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'd1));
      send_item(make_item(CMD_START, KIND_SHORT, 4'd0, 16'd1, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_START, KIND_LONG, 4'd0, 16'd1, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      // Steady tone, stop, and every preset but the long beep in turn, each cancelling the last.
      send_item(make_item(CMD_STEADY, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_STOP, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_START, KIND_CONTINUOUS, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_START, KIND_DOUBLE, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_START, KIND_TRIPLE, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_START, KIND_LONG_SHORT, 4'd0, 16'd0, 16'd0, 5'd0,
                          OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_START, KIND_BEEP, 4'd0, 16'hFFFF, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      send_item(make_item(CMD_START, KIND_SHORT, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'hFFFF));
      send_item(make_item(CMD_STOP, KIND_CUSTOM, 4'd0, 16'd0, 16'd0, 5'd0, OFF_INTERVAL, 16'd0));
      drain();

      // Random traffic under each register setting; registers change only when idle.
      for (s = 0; s < NUM_SETTINGS; s++) begin
         write_setting(s);
         run_setting(ITEMS_PER_SETTING);
         drain();
      end

      $display("Summary: %0d commands sent across %0d register settings plus directed cases.",
               commands_sent, NUM_SETTINGS);
      $display("Summary: %0d results compared, %0d patterns ran to their end.",
               checked_count, completed_count);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
